/* hdl/fatlb_pkg.sv */
// fatlb_pkg: shared types and constants of the fully associative translation buffer
// holds the controller state type, the controller/datapath command and status structs
// no dependencies

package fatlb_pkg;

   // fixed field widths
   localparam int DATA_W = 32;
   localparam int LFSR_W = 16;

   // victim lfsr state after reset
   localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

   // operation codes of an input item
   localparam logic OP_LOOKUP = 1'b0;
   localparam logic OP_INSERT = 1'b1;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_REDUCE,
      ST_RESPOND
   } fsm_state_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;      // capture a new item
      logic lookup;    // tag compare, frame read, hit or miss count
      logic fill;      // write the next free slot
      logic lfsr_step; // advance the lfsr and start the victim reduction
      logic replace;   // write the reduced victim slot
   } dp_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic insert;       // held item is an insert
      logic full;         // every slot is filled
      logic victim_ready; // victim slot index has been reduced
   } dp_status_type;

endpackage

/* hdl/fatlb_victim_mod.sv */
// fatlb_victim_mod: lfsr value modulo the entry count, as an estimate step and then a correcting step
// reciprocal multiply gives a quotient estimate, one correcting subtract fixes it; uses fatlb_pkg

module fatlb_victim_mod #(
   parameter int ENTRIES = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [fatlb_pkg::LFSR_W-1:0]         value,
   output logic                                 done,
   output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] remainder
);
   import fatlb_pkg::*;

   localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int PROD_W = 2 * LFSR_W;
   localparam logic [IDX_W:0]    MODULUS = (IDX_W + 1)'(ENTRIES);
   localparam logic [LFSR_W-1:0] DIVISOR = LFSR_W'(ENTRIES);
   // floor of 2^16 over the entry count: the estimate is the quotient or one below it
   localparam logic [PROD_W-1:0] RECIP = PROD_W'((1 << LFSR_W) / ENTRIES);

   logic              run_ff, run_in;
   logic [LFSR_W-1:0] val_ff, val_in;
   logic [LFSR_W-1:0] quot_ff, quot_in;
   logic [IDX_W-1:0]  rem_ff, rem_in;
   logic [PROD_W-1:0] recip_prod;
   logic [LFSR_W-1:0] back_prod;
   logic [LFSR_W-1:0] diff;
   logic [IDX_W:0]    rem_wide;

   // start registers the quotient estimate, then the running step registers the remainder below the entry count
   always_comb begin
      recip_prod = {{LFSR_W{1'b0}}, value} * RECIP;
      back_prod  = quot_ff * DIVISOR;
      diff       = val_ff - back_prod;
      rem_wide   = diff[IDX_W:0];
      run_in     = start;
      val_in     = val_ff;
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      if (start) begin
         val_in  = value;
         quot_in = recip_prod[PROD_W-1:LFSR_W];
      end
      if (run_ff) begin
         rem_in = (rem_wide >= MODULUS) ? IDX_W'(rem_wide - MODULUS) : rem_wide[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
      end
   end

   // dividend, quotient and remainder are payload
   always_ff @(posedge clock) begin
      val_ff  <= val_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   assign done      = !run_ff;
   assign remainder = rem_ff;

   // remainder always below the entry count once computed
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      run_ff |=> ({1'b0, rem_ff} < MODULUS))
      else $error("victim remainder out of range");

   // a start always deasserts done before the result is ready
   a_start_runs: assert property (@(posedge clock) disable iff (reset)
      start |=> !done)
      else $error("victim reduction finished without stepping");

   // the remainder step ends the reduction unless a new start arrives
   a_one_step: assert property (@(posedge clock) disable iff (reset)
      (run_ff && !start) |=> done)
      else $error("victim reduction did not finish");

endmodule

/* hdl/fatlb_ctrl.sv */
// fatlb_ctrl: controller state machine of the translation buffer
// sequences compare, victim reduction and response; uses fatlb_pkg

module fatlb_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   output logic                     rsp_valid,
   output fatlb_pkg::dp_cmd_type    cmd,
   input  fatlb_pkg::dp_status_type status
);
   import fatlb_pkg::*;

   fsm_state_type state_ff, state_in;
   logic          accept;

   assign accept = start && !busy;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_COMPARE;
         end
         ST_COMPARE: begin
            if (status.insert && status.full) state_in = ST_REDUCE;
            else                              state_in = ST_RESPOND;
         end
         ST_REDUCE: begin
            if (status.victim_ready) state_in = ST_RESPOND;
         end
         ST_RESPOND: begin
            state_in = start ? ST_COMPARE : ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // outputs and datapath commands
   always_comb begin
      cmd       = '0;
      busy      = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load = start;
         end
         ST_COMPARE: begin
            busy          = 1'b1;
            cmd.lookup    = !status.insert;
            cmd.fill      = status.insert && !status.full;
            cmd.lfsr_step = status.insert && status.full;
         end
         ST_REDUCE: begin
            busy        = 1'b1;
            cmd.replace = status.victim_ready;
         end
         ST_RESPOND: begin
            rsp_valid = 1'b1;
            cmd.load  = start;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   // an accepted item always goes to the compare step
   a_accept_compare: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_COMPARE))
      else $error("accepted item did not enter compare");

   // one strobe per item, never two in a row
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held for two cycles");

   // at most one storing command at a time
   a_one_action: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.lookup, cmd.fill, cmd.lfsr_step, cmd.replace}))
      else $error("conflicting datapath commands");

   // the response always follows a compare or a replacement
   a_respond_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(state_ff) == ST_COMPARE || $past(cmd.replace)))
      else $error("response without completed work");

endmodule

/* hdl/fatlb_dp.sv */
// fatlb_dp: datapath of the translation buffer
// tag cells, frame memory, counters, victim lfsr; uses fatlb_pkg and fatlb_victim_mod

module fatlb_dp #(
   parameter int ENTRIES = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  fatlb_pkg::dp_cmd_type            cmd,
   output fatlb_pkg::dp_status_type         status,
   input  logic                             req_operation,
   input  logic [fatlb_pkg::DATA_W-1:0]     req_virtual_page,
   input  logic [fatlb_pkg::DATA_W-1:0]     req_physical_page,
   output logic                             rsp_hit,
   output logic [fatlb_pkg::DATA_W-1:0]     rsp_physical_result,
   output logic [fatlb_pkg::DATA_W-1:0]     rsp_hits_total,
   output logic [fatlb_pkg::DATA_W-1:0]     rsp_misses_total
);
   import fatlb_pkg::*;

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);

   // held item
   logic              op_ff;
   logic [DATA_W-1:0] vpage_ff;
   logic [DATA_W-1:0] ppage_ff;

   // stores
   logic [DATA_W-1:0] tag_ff [ENTRIES];
   logic [DATA_W-1:0] frame_mem [ENTRIES];
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]  filled_ff, filled_in;

   // counters and response
   logic [DATA_W-1:0] hits_ff, hits_in;
   logic [DATA_W-1:0] misses_ff, misses_in;
   logic [LFSR_W-1:0] lfsr_ff, lfsr_in, lfsr_next;
   logic              hit_ff, hit_in;
   logic [DATA_W-1:0] frame_rd_ff;

   // compare and selection
   logic [ENTRIES-1:0] match;
   logic               any_match;
   logic [IDX_W-1:0]   match_idx;
   logic [IDX_W-1:0]   victim_idx;
   logic [IDX_W-1:0]   wr_idx;
   logic               wr_en;
   logic               victim_done;
   logic               full;

   // item capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_operation;
         vpage_ff <= req_virtual_page;
         ppage_ff <= req_physical_page;
      end
   end

   // parallel tag compare against every valid cell
   always_comb begin
      for (int k = 0; k < ENTRIES; k++) begin
         match[k] = valid_ff[k] && (tag_ff[k] == vpage_ff);
      end
   end

   // lowest matching slot wins
   always_comb begin
      match_idx = '0;
      for (int k = ENTRIES - 1; k >= 0; k--) begin
         if (match[k]) match_idx = IDX_W'(k);
      end
   end

   assign any_match = |match;
   assign full      = (filled_ff == CNT_W'(ENTRIES));

   // fibonacci lfsr, taps 16 14 13 11
   assign lfsr_next = {lfsr_ff[0] ^ lfsr_ff[2] ^ lfsr_ff[3] ^ lfsr_ff[5],
                       lfsr_ff[LFSR_W-1:1]};

   // victim slot reduction
   fatlb_victim_mod #(
      .ENTRIES (ENTRIES)
   ) u_victim_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.lfsr_step),
      .value     (lfsr_next),
      .done      (victim_done),
      .remainder (victim_idx)
   );

   // write port shared by fill and replacement
   assign wr_en  = cmd.fill || cmd.replace;
   assign wr_idx = cmd.replace ? victim_idx : IDX_W'(filled_ff);

   // control state next values
   always_comb begin
      valid_in  = valid_ff;
      filled_in = filled_ff;
      hits_in   = hits_ff;
      misses_in = misses_ff;
      lfsr_in   = lfsr_ff;
      hit_in    = hit_ff;
      if (wr_en) valid_in[wr_idx] = 1'b1;
      if (cmd.fill) filled_in = filled_ff + 1'b1;
      if (cmd.lfsr_step) lfsr_in = lfsr_next;
      if (cmd.lookup) begin
         hit_in = any_match;
         if (any_match) hits_in = hits_ff + 1'b1;
         else           misses_in = misses_ff + 1'b1;
      end
      if (wr_en) begin
         hit_in    = 1'b0;
         misses_in = misses_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         filled_ff <= '0;
         hits_ff   <= '0;
         misses_ff <= '0;
         lfsr_ff   <= LFSR_SEED;
         hit_ff    <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         filled_ff <= filled_in;
         hits_ff   <= hits_in;
         misses_ff <= misses_in;
         lfsr_ff   <= lfsr_in;
         hit_ff    <= hit_in;
      end
   end

   // tag cells
   always_ff @(posedge clock) begin
      if (wr_en) tag_ff[wr_idx] <= vpage_ff;
   end

   // frame memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) frame_mem[wr_idx] <= ppage_ff;
      if (cmd.lookup) frame_rd_ff <= frame_mem[match_idx];
   end

   assign status.insert       = (op_ff == OP_INSERT);
   assign status.full         = full;
   assign status.victim_ready = victim_done;

   assign rsp_hit             = hit_ff;
   assign rsp_physical_result = hit_ff ? frame_rd_ff : '0;
   assign rsp_hits_total      = hits_ff;
   assign rsp_misses_total    = misses_ff;

   // fill count never passes the entry count
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      filled_ff <= CNT_W'(ENTRIES))
      else $error("fill count beyond entry count");

   // valid slots are exactly the filled prefix
   a_valid_count: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == int'(filled_ff))
      else $error("valid bits disagree with fill count");

   // the lfsr never locks up at zero
   a_lfsr_live: assert property (@(posedge clock) disable iff (reset)
      lfsr_ff != '0)
      else $error("victim lfsr reached zero");

   // every lookup moves exactly one counter by one
   a_lookup_count: assert property (@(posedge clock) disable iff (reset)
      cmd.lookup |=> (hits_ff + misses_ff == $past(hits_ff) + $past(misses_ff) + 1'b1))
      else $error("lookup did not count once");

endmodule

/* hdl/fully_associative_tlb_random_replace.sv */
// fully associative translation buffer with random replacement
// lookup and insert into a non-full buffer: accept, compare, then the result strobe in the respond state;
// next item taken in the strobe cycle
// insert into a full buffer: compare, then a wait in the reduce state for the lfsr modulo unit, then respond
// synchronous active-high reset clears valid bits and counters and loads the lfsr seed; no clearing pass
// results cannot be held off by the receiver; uses fatlb_pkg, fatlb_ctrl, fatlb_dp

module fully_associative_tlb_random_replace #(
   parameter int ENTRIES = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_operation,
   input  logic [fatlb_pkg::DATA_W-1:0] req_virtual_page,
   input  logic [fatlb_pkg::DATA_W-1:0] req_physical_page,
   output logic                         rsp_valid,
   output logic                         rsp_hit,
   output logic [fatlb_pkg::DATA_W-1:0] rsp_physical_result,
   output logic [fatlb_pkg::DATA_W-1:0] rsp_hits_total,
   output logic [fatlb_pkg::DATA_W-1:0] rsp_misses_total
);
   import fatlb_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // controller
   fatlb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   // datapath
   fatlb_dp #(
      .ENTRIES (ENTRIES)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_operation       (req_operation),
      .req_virtual_page    (req_virtual_page),
      .req_physical_page   (req_physical_page),
      .rsp_hit             (rsp_hit),
      .rsp_physical_result (rsp_physical_result),
      .rsp_hits_total      (rsp_hits_total),
      .rsp_misses_total    (rsp_misses_total)
   );

endmodule
